// ===== rtl/acl_pkg.sv =====
// Shared constants for the address-resolution cache.
`timescale 1ns / 1ps
`default_nettype none

package acl_pkg;

   // Default number of cache entries.
   localparam int DEF_TABLE_ENTRIES = 4;

   // Command codes.
   localparam logic CMD_ADD     = 1'b0;
   localparam logic CMD_RESOLVE = 1'b1;

   // Multicast group block 224.0.0.0/4 and the MAC prefix it maps to.
   localparam logic [3:0]  MCAST_NET = 4'hE;
   localparam logic [23:0] MCAST_OUI = 24'h01_00_5E;

   localparam int IP_W  = 32;
   localparam int MAC_W = 48;

endpackage

`default_nettype wire

// ===== rtl/arp_cache_lookup.sv =====
// Round-robin address-resolution cache with a sequential table walk.
`timescale 1ns / 1ps
`default_nettype none

// A command transfer is taken at a rising clock edge with start high and busy low.
// An add (req_cmd = CMD_ADD) writes req_ip_addr and req_mac_in into the entry at
// the round-robin write pointer in the accepting cycle; it gives no result and
// does not raise busy, so a new command may follow in the next cycle. A resolve
// of a multicast address (224.0.0.0/4) gives 01:00:5e followed by the low 23
// address bits in the cycle after acceptance, also without raising busy. Any other
// resolve walks the table through its single memory read port, one entry per
// cycle, lowest index first; busy stays high until an entry hits or the last
// entry has been compared on a miss, and the result appears in the first
// cycle with busy low. A miss answers an all-zero MAC. The result is on rsp_mac_out
// for exactly one cycle, marked by rsp_strobe; the receiver cannot stall it and
// must take it then. Reset clears every entry to address 0.0.0.0 with a zero MAC
// at once through per-entry valid bits, so no clearing pass is needed.
module arp_cache_lookup #(
   parameter int TABLE_ENTRIES = acl_pkg::DEF_TABLE_ENTRIES
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic                     req_cmd,
   input  wire logic [acl_pkg::IP_W-1:0]  req_ip_addr,
   input  wire logic [acl_pkg::MAC_W-1:0] req_mac_in,
   output logic                          rsp_strobe,
   output logic [acl_pkg::MAC_W-1:0]      rsp_mac_out
);
   import acl_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   // Sequencer and bookkeeping.
   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     wp_ff, wp_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 issue_ff, issue_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic                 rd_last_ff, rd_last_in;
   logic [IP_W-1:0]      key_ff, key_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [MAC_W-1:0]     rsp_mac_ff, rsp_mac_in;

   // Table storage: valid bits in flip-flops, payload in memory.
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [IP_W-1:0]          entry_ip_ff  [TABLE_ENTRIES];
   logic [MAC_W-1:0]         entry_mac_ff [TABLE_ENTRIES];
   logic [IP_W-1:0]          rd_ip_ff;
   logic [MAC_W-1:0]         rd_mac_ff;
   logic                     rd_ent_ff;

   logic             accept;
   logic             add_go;
   logic             mcast;
   logic             read_en;
   logic [IP_W-1:0]  cmp_ip;
   logic [MAC_W-1:0] cmp_mac;
   logic             hit;

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign add_go  = accept && (req_cmd == CMD_ADD);
   assign mcast   = (req_ip_addr[IP_W-1:IP_W-4] == MCAST_NET);
   assign read_en = (state_ff == ST_SCAN) && issue_ff;

   // An entry that was never written since reset reads as all zero.
   assign cmp_ip  = rd_ent_ff ? rd_ip_ff  : '0;
   assign cmp_mac = rd_ent_ff ? rd_mac_ff : '0;
   assign hit     = rd_vld_ff && (cmp_ip == key_ff);

   always_comb begin
      state_in      = state_ff;
      wp_in         = wp_ff;
      idx_in        = idx_ff;
      issue_in      = issue_ff;
      rd_vld_in     = 1'b0;
      rd_last_in    = rd_last_ff;
      key_in        = key_ff;
      rsp_strobe_in = 1'b0;
      rsp_mac_in    = rsp_mac_ff;
      valid_in      = valid_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_ADD) begin
                  valid_in[wp_ff] = 1'b1;
                  wp_in = (wp_ff == LAST_IDX) ? '0 : wp_ff + 1'b1;
               end else if (mcast) begin
                  rsp_strobe_in = 1'b1;
                  rsp_mac_in    = {MCAST_OUI, 1'b0, req_ip_addr[22:0]};
               end else begin
                  key_in   = req_ip_addr;
                  idx_in   = '0;
                  issue_in = 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // Issue the next read while the previous one is compared.
            if (issue_ff) begin
               rd_vld_in  = 1'b1;
               rd_last_in = (idx_ff == LAST_IDX);
               if (idx_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            if (hit || (rd_vld_ff && rd_last_ff)) begin
               rsp_strobe_in = 1'b1;
               rsp_mac_in    = hit ? cmp_mac : '0;
               rd_vld_in     = 1'b0;
               issue_in      = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wp_ff         <= '0;
         idx_ff        <= '0;
         issue_ff      <= 1'b0;
         rd_vld_ff     <= 1'b0;
         rd_last_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         valid_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         wp_ff         <= wp_in;
         idx_ff        <= idx_in;
         issue_ff      <= issue_in;
         rd_vld_ff     <= rd_vld_in;
         rd_last_ff    <= rd_last_in;
         rsp_strobe_ff <= rsp_strobe_in;
         valid_ff      <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      rsp_mac_ff <= rsp_mac_in;
   end

   // Table memory: one write port for adds, one registered read port for the walk.
   always_ff @(posedge clock) begin
      if (add_go) begin
         entry_ip_ff[wp_ff]  <= req_ip_addr;
         entry_mac_ff[wp_ff] <= req_mac_in;
      end
      if (read_en) begin
         rd_ip_ff  <= entry_ip_ff[idx_ff];
         rd_mac_ff <= entry_mac_ff[idx_ff];
         rd_ent_ff <= valid_ff[idx_ff];
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_mac_out = rsp_mac_ff;

   // A walk always has a read in flight or one still to issue.
   a_scan_alive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (issue_ff || rd_vld_ff))
      else $error("table walk stalled with nothing in flight");

   // No stale read data survives into the idle state.
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!rd_vld_ff && !issue_ff))
      else $error("read pending while idle");

   // An add never produces a result.
   a_add_silent: assert property (@(posedge clock) disable iff (reset)
      add_go |=> !rsp_strobe)
      else $error("result after an add");

   // A multicast resolve answers in the next cycle with the group prefix.
   a_mcast_resp: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd == CMD_RESOLVE) && mcast) |=>
         (rsp_strobe && (rsp_mac_out[MAC_W-1:MAC_W-24] == MCAST_OUI)))
      else $error("multicast resolve answered wrongly");

   // The walk finishes with exactly one result and then leaves the busy state.
   a_walk_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && rd_vld_ff && rd_last_ff) |=>
         (rsp_strobe && !busy))
      else $error("walk ended without a result");

endmodule

`default_nettype wire
